// ----- hdl/fcdq_pkg.sv -----
// Shared types and constants for the floor call queue.
package fcdq_pkg;

    localparam int FLOOR_W     = 2;
    localparam int BTN_W       = 4;
    localparam int CNT_W       = 3;
    localparam int DEPTH_CMP_W = 5;
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 16;

    localparam logic ACT_SCAN    = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SELECT,
        ST_SCAN,
        ST_POP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic [CNT_W-1:0]   idx;
        logic [FLOOR_W-1:0] floor;
    } q_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [FLOOR_W-1:0] head_floor;
        logic               match;
    } q_stat_t;

endpackage

// ----- hdl/fcdq_queue.sv -----
// Floor queue storage with entry count, head shift and entry compare.
module fcdq_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  fcdq_pkg::q_ctrl_t ctrl,
    output fcdq_pkg::q_stat_t stat
);
    import fcdq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [FLOOR_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   wr_idx;

    assign rd_idx = IDX_W'(ctrl.idx);
    assign wr_idx = IDX_W'(count_reg);

    always_comb begin
        count_next = count_reg;
        if (ctrl.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.pop && count_reg != '0) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            entry_reg[wr_idx] <= ctrl.floor;
        end else if (ctrl.pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                entry_reg[i] <= entry_reg[i+1];
            end
        end
    end

    assign stat.count      = count_reg;
    assign stat.head_floor = (count_reg != '0) ? entry_reg[0] : '0;
    assign stat.match      = (entry_reg[rd_idx] == ctrl.floor);

endmodule

// ----- hdl/floor_call_dedup_queue.sv -----
// Floor call queue: a scan beat selects one call by priority (buttons 0..3, then
// the held external floor) and appends it unless that floor is already queued or
// the queue is full; an advance beat removes the head. One result beat per input
// beat. A scan runs a compare loop that walks the stored entries one per cycle
// through a single comparator. A scan or an advance waits longer
// while a previous result still sits unaccepted in the output register. The input
// side takes a new beat while the previous result still waits in that register.
module floor_call_dedup_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [3:0] button_levels, [4] ext_valid, [6:5] ext_floor
    input  logic [fcdq_pkg::S_DATA_W-1:0] s_tdata,
    // [0] action
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] added, [1] popped, [2] head_valid, [4:3] head_floor,
    // [7:5] queue_count, [8] call_pending
    output logic [fcdq_pkg::M_DATA_W-1:0] m_tdata
);
    import fcdq_pkg::*;

    localparam logic [DEPTH_CMP_W-1:0] DEPTH_L = DEPTH_CMP_W'(QUEUE_DEPTH);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               act_reg, act_next;
    logic [BTN_W-1:0]   btn_reg, btn_next;
    logic               in_ev_reg, in_ev_next;
    logic [FLOOR_W-1:0] in_ef_reg, in_ef_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [FLOOR_W-1:0] pend_floor_reg, pend_floor_next;
    logic               ext_valid_reg, ext_valid_next;
    logic [FLOOR_W-1:0] ext_floor_reg, ext_floor_next;
    logic               added_reg, added_next;
    logic               popped_reg, popped_next;
    logic               m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    q_ctrl_t            q_ctrl;
    q_stat_t            q_stat;
    logic               ext_v_now;
    logic [FLOOR_W-1:0] ext_f_now;
    logic [FLOOR_W-1:0] btn_floor;
    logic               q_full;
    logic               s_acc;

    fcdq_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (q_ctrl),
        .stat   (q_stat)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign ext_v_now = ext_valid_reg | in_ev_reg;
    assign ext_f_now = in_ev_reg ? in_ef_reg : ext_floor_reg;
    assign q_full    = ({{(DEPTH_CMP_W-CNT_W){1'b0}}, q_stat.count} >= DEPTH_L);

    always_comb begin
        if (btn_reg[0]) begin
            btn_floor = FLOOR_W'(0);
        end else if (btn_reg[1]) begin
            btn_floor = FLOOR_W'(1);
        end else if (btn_reg[2]) begin
            btn_floor = FLOOR_W'(2);
        end else begin
            btn_floor = FLOOR_W'(3);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            pend_floor_reg <= '0;
            ext_valid_reg  <= 1'b0;
            ext_floor_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            pend_floor_reg <= pend_floor_next;
            ext_valid_reg  <= ext_valid_next;
            ext_floor_reg  <= ext_floor_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        act_reg    <= act_next;
        btn_reg    <= btn_next;
        in_ev_reg  <= in_ev_next;
        in_ef_reg  <= in_ef_next;
        added_reg  <= added_next;
        popped_reg <= popped_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        act_next        = act_reg;
        btn_next        = btn_reg;
        in_ev_next      = in_ev_reg;
        in_ef_next      = in_ef_reg;
        pend_valid_next = pend_valid_reg;
        pend_floor_next = pend_floor_reg;
        ext_valid_next  = ext_valid_reg;
        ext_floor_next  = ext_floor_reg;
        added_next      = added_reg;
        popped_next     = popped_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        q_ctrl.push     = 1'b0;
        q_ctrl.pop      = 1'b0;
        q_ctrl.idx      = idx_reg;
        q_ctrl.floor    = pend_floor_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    act_next    = s_tuser;
                    btn_next    = s_tdata[BTN_W-1:0];
                    in_ev_next  = s_tdata[BTN_W];
                    in_ef_next  = s_tdata[BTN_W+FLOOR_W:BTN_W+1];
                    added_next  = 1'b0;
                    popped_next = 1'b0;
                    idx_next    = '0;
                    state_next  = (s_tuser == ACT_ADVANCE) ? ST_POP : ST_SELECT;
                end
            end
            ST_SELECT: begin
                ext_valid_next = ext_v_now;
                ext_floor_next = ext_f_now;
                if (btn_reg != '0) begin
                    pend_valid_next = 1'b1;
                    pend_floor_next = btn_floor;
                end else if (ext_v_now) begin
                    pend_valid_next = 1'b1;
                    pend_floor_next = ext_f_now;
                    ext_valid_next  = 1'b0;
                end
                state_next = (pend_valid_next && !q_full) ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN: begin
                if (idx_reg == q_stat.count) begin
                    q_ctrl.push     = 1'b1;
                    pend_valid_next = 1'b0;
                    added_next      = 1'b1;
                    state_next      = ST_FINISH;
                end else if (q_stat.match) begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_FINISH;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_POP: begin
                if (q_stat.count != '0) begin
                    q_ctrl.pop  = 1'b1;
                    popped_next = 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'b0, pend_valid_reg, q_stat.count, q_stat.head_floor,
                                    (q_stat.count != '0), popped_reg, added_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // duplicate suppression bounds the queue to the four floors
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= CNT_W'(4) && {2'b00, q_stat.count} <= DEPTH_L)
        else $error("queue count out of range");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("accepted a beat while busy");

    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("add and pop in one beat");

    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2] == (m_tdata[7:5] != 3'd0)))
        else $error("head_valid disagrees with count");

    a_added_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[7:5] != 3'd0 && !m_tdata[8]))
        else $error("append left queue empty or call pending");

endmodule

// ----- verif/floor_call_dedup_queue_tb.sv -----
// Self-checking testbench for the floor call queue with duplicate suppression.
`timescale 1ns / 100ps

module floor_call_dedup_queue_tb;
    import fcdq_pkg::*;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic               action;
        logic [BTN_W-1:0]   buttons;
        logic               ext_valid;
        logic [FLOOR_W-1:0] ext_floor;
    } floor_scan_t;

    typedef struct packed {
        logic               added;
        logic               popped;
        logic               head_valid;
        logic [FLOOR_W-1:0] head_floor;
        logic [CNT_W-1:0]   count;
        logic               call_pending;
    } stop_status_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    floor_scan_t  scan_items[$];
    stop_status_t pending_stops[$];
    floor_scan_t  next_scan;
    int           beats_queued = 0;
    int           beats_in     = 0;
    int           errors       = 0;
    logic         in_taken     = 1'b0;
    int           burst_left   = 0;
    int           gap_left     = 0;
    int           stall_mode   = 0;
    int           phase_left   = 0;
    int           holdoff_left = 0;
    logic         holdoff_done = 1'b0;

    // predictor state
    logic [FLOOR_W-1:0] call_queue[QUEUE_DEPTH];
    int                 stored     = 0;
    logic               pend_v     = 1'b0;
    logic [FLOOR_W-1:0] pend_f     = '0;
    logic               ext_held_v = 1'b0;
    logic [FLOOR_W-1:0] ext_held_f = '0;

    floor_call_dedup_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic queue_beat(input logic act, input int btn, input logic ev, input int ef);
        floor_scan_t item;
        item.action    = act;
        item.buttons   = BTN_W'(btn);
        item.ext_valid = ev;
        item.ext_floor = FLOOR_W'(ef);
        scan_items.push_back(item);
        beats_queued++;
    endtask

    task automatic predict_stop(input floor_scan_t scan);
        stop_status_t st;
        logic         dup;
        st = '0;
        if (scan.action == ACT_SCAN) begin
            if (scan.ext_valid) begin
                ext_held_v = 1'b1;
                ext_held_f = scan.ext_floor;
            end
            if (scan.buttons != '0) begin
                for (int n = BTN_W - 1; n >= 0; n--)
                    if (scan.buttons[n]) pend_f = FLOOR_W'(n);
                pend_v = 1'b1;
            end else if (ext_held_v) begin
                pend_f     = ext_held_f;
                pend_v     = 1'b1;
                ext_held_v = 1'b0;
            end
            if (pend_v && stored < QUEUE_DEPTH) begin
                dup = 1'b0;
                for (int i = 0; i < stored; i++)
                    if (call_queue[i] == pend_f) dup = 1'b1;
                if (!dup) begin
                    call_queue[stored] = pend_f;
                    stored++;
                    st.added = 1'b1;
                end
                pend_v = 1'b0;
            end
        end else if (stored > 0) begin
            for (int i = 0; i < stored - 1; i++)
                call_queue[i] = call_queue[i + 1];
            stored--;
            st.popped = 1'b1;
        end
        st.head_valid   = (stored > 0);
        st.head_floor   = (stored > 0) ? call_queue[0] : '0;
        st.count        = CNT_W'(stored);
        st.call_pending = pend_v;
        pending_stops.push_back(st);
    endtask

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    // checker first, then predictor, so a fresh expectation is never matched early
    always @(posedge aclk) begin
        stop_status_t want;
        floor_scan_t  seen;
        in_taken <= s_tvalid && s_tready && aresetn;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_stops.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = pending_stops.pop_front();
                    check_field("added",        want.added,        m_tdata[0]);
                    check_field("popped",       want.popped,       m_tdata[1]);
                    check_field("head_valid",   want.head_valid,   m_tdata[2]);
                    check_field("head_floor",   want.head_floor,   m_tdata[4:3]);
                    check_field("queue_count",  want.count,        m_tdata[7:5]);
                    check_field("call_pending", want.call_pending, m_tdata[8]);
                end
            end
            if (s_tvalid && s_tready) begin
                seen.action    = s_tuser;
                seen.buttons   = s_tdata[3:0];
                seen.ext_valid = s_tdata[4];
                seen.ext_floor = s_tdata[6:5];
                predict_stop(seen);
                beats_in <= beats_in + 1;
            end
        end
    end

    // sender: bursts with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (scan_items.size() > 0) begin
                next_scan = scan_items.pop_front();
                s_tvalid  <= 1'b1;
                s_tuser   <= next_scan.action;
                s_tdata   <= {1'b0, next_scan.ext_floor, next_scan.ext_valid, next_scan.buttons};
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (phase_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            phase_left <= $urandom_range(16, 80);
        end else begin
            phase_left <= phase_left - 1;
        end
    end

    // receiver: stall pattern plus one long hold-off to back up the input
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holdoff_left > 0) begin
            m_tready     <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (!holdoff_done && beats_in >= 400) begin
            m_tready     <= 1'b0;
            holdoff_left <= 200;
            holdoff_done <= 1'b1;
        end else begin
            case (stall_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= $urandom_range(0, 1);
                end
                default: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    initial begin
        int adv_pct;
        int btn;

        // directed: empty advance, priority, held external, duplicates, full queue
        queue_beat(ACT_ADVANCE, 0,       1'b0, 0);
        queue_beat(ACT_SCAN,    0,       1'b0, 0);
        queue_beat(ACT_SCAN,    4'b1111, 1'b1, 3);
        queue_beat(ACT_SCAN,    0,       1'b0, 0);
        queue_beat(ACT_SCAN,    4'b0010, 1'b0, 0);
        queue_beat(ACT_SCAN,    4'b1000, 1'b1, 2);
        queue_beat(ACT_SCAN,    0,       1'b0, 0);
        queue_beat(ACT_SCAN,    4'b0100, 1'b1, 1);
        queue_beat(ACT_SCAN,    0,       1'b0, 0);
        queue_beat(ACT_ADVANCE, 4'b1111, 1'b1, 3);
        queue_beat(ACT_SCAN,    0,       1'b0, 0);
        queue_beat(ACT_SCAN,    4'b0001, 1'b0, 0);
        queue_beat(ACT_SCAN,    0,       1'b1, 1);
        queue_beat(ACT_SCAN,    0,       1'b1, 3);
        queue_beat(ACT_ADVANCE, 0,       1'b0, 0);
        queue_beat(ACT_ADVANCE, 0,       1'b0, 0);
        queue_beat(ACT_ADVANCE, 0,       1'b0, 0);
        queue_beat(ACT_ADVANCE, 0,       1'b0, 0);
        queue_beat(ACT_ADVANCE, 0,       1'b0, 0);
        queue_beat(ACT_SCAN,    0,       1'b0, 0);
        queue_beat(ACT_SCAN,    4'b0010, 1'b1, 1);
        queue_beat(ACT_SCAN,    4'b0010, 1'b1, 2);
        queue_beat(ACT_SCAN,    0,       1'b1, 0);
        queue_beat(ACT_ADVANCE, 0,       1'b0, 0);

        adv_pct = 35;
        for (int i = 0; i < 1300; i++) begin
            if (i % 100 == 0) adv_pct = $urandom_range(15, 60);
            case ($urandom_range(0, 3))
                0: btn = $urandom_range(0, 15);
                1: btn = 1 << $urandom_range(0, 3);
                default: btn = 0;
            endcase
            queue_beat(($urandom_range(0, 99) < adv_pct) ? ACT_ADVANCE : ACT_SCAN,
                       btn, ($urandom_range(0, 2) == 0), $urandom_range(0, 3));
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (beats_in == beats_queued);
        wait (pending_stops.size() == 0);
        repeat (30) @(posedge aclk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
